[rtl/assert_macros.svh]
// Assertion helpers used by the deframer unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, held off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication check, held off while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/mlfd_pkg.sv]
`timescale 1ns / 1ps

package mlfd_pkg;

	localparam int unsigned BUF_BYTES = 4096;
	localparam int unsigned HDR_LEN = 8;
	localparam logic [31:0] LEN_LIMIT = 32'(BUF_BYTES - HDR_LEN);

	typedef enum logic [1:0] {
		REG_MAGIC_FIRST  = 2'd0,
		REG_MAGIC_SECOND = 2'd1,
		REG_MAX_PAYLOAD  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] oversized_count;
		logic        last;
		logic [11:0] byte_index;
		logic        byte_valid;
		logic [7:0]  payload_byte;
		logic [11:0] frame_length;
		logic [7:0]  frame_id;
		logic [7:0]  frame_type;
	} result_t;

endpackage

[rtl/magic_length_frame_deframer_unit.sv]
// Each result word is registered in the output register, or in the skid register while the output is stalled.
// Throughput: one byte per cycle while the skid register is empty; an output register plus a skid register keep
// the slave side open while one result waits for the downstream consumer.
// Reset (arst_n low, asynchronous): hunting for a header with no bytes held, tally zero,
// magic registers 0xA5/0x5A, maximum payload 4088.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module magic_length_frame_deframer_unit import mlfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] frame_type, [15:8] frame_id, [27:16] frame_length, [35:28] payload_byte,
	// [47:36] byte_index, [63:48] oversized_count
	output logic [63:0] m_tdata,
	output logic        m_tuser,   // [0] byte_valid
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]  magic_first_q;
	logic [7:0]  magic_second_q;
	logic [11:0] max_payload_q;

	logic [7:0]  hdr_q [HDR_LEN];
	logic [3:0]  hdr_fill_q;
	logic        in_payload_q;
	logic [11:0] left_q;
	logic [11:0] pos_q;
	logic [7:0]  cur_type_q;
	logic [7:0]  cur_id_q;
	logic [11:0] cur_len_q;
	logic [15:0] tally_q;

	logic [7:0]  hdr_n [HDR_LEN];
	logic [3:0]  hdr_fill_n;
	logic        in_payload_n;
	logic [11:0] left_n;
	logic [11:0] pos_n;
	logic [7:0]  cur_type_n;
	logic [7:0]  cur_id_n;
	logic [11:0] cur_len_n;
	logic [15:0] tally_n;

	logic [7:0]  hdr_full [HDR_LEN];
	logic [7:0]  hdr_shift [HDR_LEN];
	logic [2:0]  hit_pos;
	logic        hit;
	logic        magic_ok;
	logic        size_ok;
	logic [31:0] frame_len;
	logic        fin;

	result_t     res;
	logic        has_res;
	logic        in_fire;
	logic        cfg_wr;

	result_t     out_q;
	logic        out_valid_q;
	result_t     skid_q;
	logic        skid_valid_q;
	logic        pop;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_first_q  <= 8'd165;
			magic_second_q <= 8'd90;
			max_payload_q  <= 12'd4088;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_MAGIC_FIRST:  magic_first_q  <= pwdata[7:0];
				REG_MAGIC_SECOND: magic_second_q <= pwdata[7:0];
				REG_MAX_PAYLOAD:  max_payload_q  <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_MAGIC_FIRST:  prdata = {24'd0, magic_first_q};
			REG_MAGIC_SECOND: prdata = {24'd0, magic_second_q};
			REG_MAX_PAYLOAD:  prdata = {20'd0, max_payload_q};
			default:          prdata = 32'd0;
		endcase
	end

	// Header as it stands once the incoming byte is placed.
	always_comb begin
		for (int j = 0; j < HDR_LEN; j++) begin
			hdr_full[j] = (3'(j) == hdr_fill_q[2:0]) ? s_tdata : hdr_q[j];
		end
	end

	// Resync search: first position 1..6 holding the magic pair.
	always_comb begin
		hit = 1'b0;
		hit_pos = 3'd0;
		for (int k = HDR_LEN - 2; k >= 1; k--) begin
			if (hdr_full[k] == magic_first_q && hdr_full[k + 1] == magic_second_q) begin
				hit = 1'b1;
				hit_pos = 3'(k);
			end
		end
		// Entries that wrap around land past the new fill point and are rewritten first.
		for (int j = 0; j < HDR_LEN; j++) begin
			hdr_shift[j] = hdr_full[3'(j) + hit_pos];
		end
	end

	assign frame_len = {hdr_full[7], hdr_full[6], hdr_full[5], hdr_full[4]};
	assign magic_ok  = (hdr_full[0] == magic_first_q) && (hdr_full[1] == magic_second_q);
	assign size_ok   = (frame_len <= {20'd0, max_payload_q}) && (frame_len <= LEN_LIMIT);
	assign fin       = (left_q <= 12'd1);

	always_comb begin
		hdr_n        = hdr_q;
		hdr_fill_n   = hdr_fill_q;
		in_payload_n = in_payload_q;
		left_n       = left_q;
		pos_n        = pos_q;
		cur_type_n   = cur_type_q;
		cur_id_n     = cur_id_q;
		cur_len_n    = cur_len_q;
		tally_n      = tally_q;
		has_res      = 1'b0;

		res.frame_type      = cur_type_q;
		res.frame_id        = cur_id_q;
		res.frame_length    = cur_len_q;
		res.payload_byte    = s_tdata;
		res.byte_valid      = 1'b1;
		res.byte_index      = pos_q;
		res.last            = fin;
		res.oversized_count = tally_q;

		if (in_payload_q) begin
			has_res = 1'b1;
			pos_n   = pos_q + 12'd1;
			left_n  = left_q - 12'd1;
			if (fin) begin
				in_payload_n = 1'b0;
				left_n       = 12'd0;
			end
		end else begin
			hdr_n      = hdr_full;
			hdr_fill_n = hdr_fill_q + 4'd1;
			if (hdr_fill_q == 4'(HDR_LEN - 1)) begin
				if (!magic_ok || !size_ok) begin
					if (magic_ok && tally_q != 16'hFFFF) begin
						tally_n = tally_q + 16'd1;
					end
					if (hit) begin
						hdr_n      = hdr_shift;
						hdr_fill_n = 4'(HDR_LEN) - {1'b0, hit_pos};
					end else begin
						hdr_fill_n = 4'd0;
					end
				end else begin
					cur_type_n = hdr_full[2];
					cur_id_n   = hdr_full[3];
					cur_len_n  = frame_len[11:0];
					hdr_fill_n = 4'd0;
					pos_n      = 12'd0;
					if (frame_len == 32'd0) begin
						left_n              = 12'd0;
						has_res             = 1'b1;
						res.frame_type      = hdr_full[2];
						res.frame_id        = hdr_full[3];
						res.frame_length    = 12'd0;
						res.payload_byte    = 8'd0;
						res.byte_valid      = 1'b0;
						res.byte_index      = 12'd0;
						res.last            = 1'b1;
					end else begin
						left_n       = frame_len[11:0];
						in_payload_n = 1'b1;
					end
				end
			end
		end
	end

	assign s_tready = !skid_valid_q;
	assign in_fire  = s_tvalid & s_tready;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			hdr_q <= hdr_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_fill_q   <= 4'd0;
			in_payload_q <= 1'b0;
			left_q       <= 12'd0;
			pos_q        <= 12'd0;
			cur_type_q   <= 8'd0;
			cur_id_q     <= 8'd0;
			cur_len_q    <= 12'd0;
			tally_q      <= 16'd0;
		end else if (in_fire) begin
			hdr_fill_q   <= hdr_fill_n;
			in_payload_q <= in_payload_n;
			left_q       <= left_n;
			pos_q        <= pos_n;
			cur_type_q   <= cur_type_n;
			cur_id_q     <= cur_id_n;
			cur_len_q    <= cur_len_n;
			tally_q      <= tally_n;
		end
	end

	// Output register with a skid register behind it.
	assign pop = out_valid_q & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_fire && has_res) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (in_fire && has_res) begin
			if (out_valid_q && !pop) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.oversized_count, out_q.byte_index, out_q.payload_byte,
		out_q.frame_length, out_q.frame_id, out_q.frame_type};
	assign m_tuser  = out_q.byte_valid;
	assign m_tlast  = out_q.last;

	`ASSERT_IMP(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q,
		"skid register holds a word while the output register is empty")
	`ASSERT_IMP(a_payload_no_hdr, clk, arst_n, in_payload_q, hdr_fill_q == 4'd0,
		"header bytes held while a payload is in progress")
	`ASSERT_CLK(a_tally_monotonic, clk, arst_n, ##1 (tally_q >= $past(tally_q)),
		"oversize tally went down")
	`ASSERT_IMP(a_payload_left, clk, arst_n, in_payload_q, left_q != 12'd0,
		"payload in progress with no bytes left")

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import mlfd_pkg::*;

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_PERIODIC,
		RX_SPARSE
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [7:0] frame_type, [15:8] frame_id, [27:16] frame_length, [35:28] payload_byte,
	// [47:36] byte_index, [63:48] oversized_count
	logic [63:0] m_tdata;
	logic        m_tuser;           // [0] byte_valid
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = 4'h0;
	logic [31:0] pwdata = 32'h0;
	logic [31:0] prdata;
	logic        pready;

	magic_length_frame_deframer_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Register copies as the block should hold them.
	logic [7:0]  magic0 = 8'd165;
	logic [7:0]  magic1 = 8'd90;
	logic [11:0] max_len = 12'd4088;

	// Deframer state as predicted.
	logic [7:0]  hdr [8] = '{default: 8'h00};
	logic [3:0]  hdr_fill = '0;
	logic        in_body = 1'b0;
	logic [11:0] body_left = '0;
	logic [11:0] body_pos = '0;
	logic [7:0]  cur_type = '0;
	logic [7:0]  cur_id = '0;
	logic [11:0] cur_len = '0;
	logic [15:0] reject_tally = '0;

	logic [7:0] rx_bytes [$];
	result_t    frame_words [$];
	int         errors = 0;

	function automatic void note_error(string what, longint unsigned want, longint unsigned got);
		errors++;
		if (errors <= 10)
			$display("mismatch on %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
	endfunction

	function automatic void queue_frame_word(logic [7:0] pb, logic valid, logic [11:0] idx,
			logic fin);
		result_t w;
		w.frame_type = cur_type;
		w.frame_id = cur_id;
		w.frame_length = cur_len;
		w.payload_byte = pb;
		w.byte_valid = valid;
		w.byte_index = idx;
		w.last = fin;
		w.oversized_count = reject_tally;
		frame_words.push_back(w);
	endfunction

	// Look for the magic pair at header positions 1 to 6 and keep the bytes from there.
	function automatic void rehunt_header();
		bit hit;
		hit = 1'b0;
		for (int k = 1; k < 7; k++) begin
			if (!hit && hdr[k] == magic0 && hdr[k + 1] == magic1) begin
				for (int j = 0; j < 8 - k; j++)
					hdr[j] = hdr[j + k];
				hdr_fill = 4'(8 - k);
				hit = 1'b1;
			end
		end
		if (!hit)
			hdr_fill = '0;
	endfunction

	function automatic void deframe_byte(logic [7:0] b);
		logic        fin;
		logic [31:0] len;
		if (in_body) begin
			fin = (body_left <= 12'd1);
			queue_frame_word(b, 1'b1, body_pos, fin);
			body_pos = body_pos + 12'd1;
			body_left = body_left - 12'd1;
			if (fin) begin
				in_body = 1'b0;
				body_left = '0;
			end
			return;
		end
		hdr[hdr_fill[2:0]] = b;
		hdr_fill = hdr_fill + 4'd1;
		if (hdr_fill < 4'(HDR_LEN))
			return;
		if (hdr[0] != magic0 || hdr[1] != magic1) begin
			rehunt_header();
			return;
		end
		len = {hdr[7], hdr[6], hdr[5], hdr[4]};
		if (len > 32'(max_len) || len > 32'(BUF_BYTES - HDR_LEN)) begin
			if (reject_tally != 16'hFFFF)
				reject_tally = reject_tally + 16'd1;
			rehunt_header();
			return;
		end
		cur_type = hdr[2];
		cur_id = hdr[3];
		cur_len = len[11:0];
		hdr_fill = '0;
		body_pos = '0;
		if (len == 0) begin
			body_left = '0;
			queue_frame_word(8'h00, 1'b0, 12'd0, 1'b1);
			return;
		end
		body_left = cur_len;
		in_body = 1'b1;
	endfunction

	// Output words are checked before the input word of the same edge is predicted,
	// so a result never meets an expectation queued at the same edge.
	logic in_took = 1'b0;
	always @(posedge clk) begin : watch
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (frame_words.size() == 0) begin
				note_error("unexpected word", 0, m_tdata);
			end else begin
				want = frame_words.pop_front();
				if (m_tdata[7:0] !== want.frame_type)
					note_error("frame_type", want.frame_type, m_tdata[7:0]);
				if (m_tdata[15:8] !== want.frame_id)
					note_error("frame_id", want.frame_id, m_tdata[15:8]);
				if (m_tdata[27:16] !== want.frame_length)
					note_error("frame_length", want.frame_length, m_tdata[27:16]);
				if (m_tdata[35:28] !== want.payload_byte)
					note_error("payload_byte", want.payload_byte, m_tdata[35:28]);
				if (m_tdata[47:36] !== want.byte_index)
					note_error("byte_index", want.byte_index, m_tdata[47:36]);
				if (m_tdata[63:48] !== want.oversized_count)
					note_error("oversized_count", want.oversized_count, m_tdata[63:48]);
				if (m_tuser !== want.byte_valid)
					note_error("byte_valid", want.byte_valid, m_tuser);
				if (m_tlast !== want.last)
					note_error("last", want.last, m_tlast);
			end
		end
		in_took <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			deframe_byte(s_tdata);
			void'(rx_bytes.pop_front());
		end
	end

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 1;
	int gap_left = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_took) begin
			if (gap_left != 0) begin
				s_tvalid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (rx_bytes.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= rx_bytes[0];
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: switches at random between stall patterns.
	rx_mode_t    rx_mode = RX_OPEN;
	int          rx_left = 0;
	int          rx_period = 3;
	int unsigned rx_tick = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
				rx_left <= $urandom_range(30, 300);
				rx_period <= $urandom_range(2, 7);
			end else begin
				rx_left <= rx_left - 1;
			end
			rx_tick <= rx_tick + 1;
			case (rx_mode)
				RX_OPEN: m_tready <= 1'b1;
				RX_COIN: m_tready <= ($urandom_range(0, 1) == 1);
				RX_PERIODIC: m_tready <= ((rx_tick % rx_period) != 0);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic apb_write(input logic [3:0] addr, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apb_read_check(input reg_idx_t r);
		logic [31:0] want;
		case (r)
			REG_MAGIC_FIRST: want = {24'h0, magic0};
			REG_MAGIC_SECOND: want = {24'h0, magic1};
			default: want = {20'h0, max_len};
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {r, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want)
			note_error("register read", want, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_set(input reg_idx_t r, input logic [31:0] val);
		apb_write({r, 2'b00}, val);
		case (r)
			REG_MAGIC_FIRST: magic0 = val[7:0];
			REG_MAGIC_SECOND: magic1 = val[7:0];
			default: max_len = val[11:0];
		endcase
		apb_read_check(r);
	endtask

	task automatic set_framing(input logic [7:0] m0, input logic [7:0] m1,
			input logic [11:0] mx);
		reg_set(REG_MAGIC_FIRST, {24'h0, m0});
		reg_set(REG_MAGIC_SECOND, {24'h0, m1});
		reg_set(REG_MAX_PAYLOAD, {20'h0, mx});
	endtask

	// Waits until every byte is taken and every word has come out, then lets the
	// pipeline drain, since a byte may still be in flight without a result.
	task automatic wait_quiet();
		while (rx_bytes.size() != 0 || s_tvalid || frame_words.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic send_header(input logic [7:0] t, input logic [7:0] id,
			input logic [31:0] len, input int keep);
		logic [7:0] h [8];
		h = '{magic0, magic1, t, id, len[7:0], len[15:8], len[23:16], len[31:24]};
		for (int i = 0; i < keep; i++)
			rx_bytes.push_back(h[i]);
	endtask

	task automatic send_frame(input logic [7:0] t, input logic [7:0] id, input logic [31:0] len);
		send_header(t, id, len, 8);
		for (int i = 0; i < int'(len); i++)
			rx_bytes.push_back(8'($urandom));
	endtask

	function automatic int pick_len(input int top);
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return $urandom_range(0, (top < 8) ? top : 8);
		if (r < 9)
			return $urandom_range(0, (top < 40) ? top : 40);
		return $urandom_range(0, (top < 200) ? top : 200);
	endfunction

	// Mostly well-formed frames with random content, the rest oversize headers,
	// cut-off headers and noise with stray magic bytes.
	task automatic random_traffic(input int n_bytes);
		int          goal;
		int          r;
		int          top;
		logic [31:0] len;
		goal = rx_bytes.size() + n_bytes;
		top = (int'(max_len) < 4088) ? int'(max_len) : 4088;
		while (rx_bytes.size() < goal) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_frame(8'($urandom), 8'($urandom), 32'(pick_len(top)));
			end else if (r < 80) begin
				if ($urandom_range(0, 3) == 0)
					len = $urandom | 32'h0001_0000;
				else if (max_len < 12'd4088)
					len = $urandom_range(int'(max_len) + 1, int'(max_len) + 20);
				else
					len = $urandom_range(4089, 4095);
				send_header(8'($urandom), 8'($urandom), len, 8);
			end else if (r < 90) begin
				send_header(8'($urandom), 8'($urandom), 32'(pick_len(top)),
					$urandom_range(1, 7));
			end else begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 5))
						0: rx_bytes.push_back(magic0);
						1: rx_bytes.push_back(magic1);
						default: rx_bytes.push_back(8'($urandom));
					endcase
				end
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values of the registers.
		apb_read_check(REG_MAGIC_FIRST);
		apb_read_check(REG_MAGIC_SECOND);
		apb_read_check(REG_MAX_PAYLOAD);

		// Zero-length marker, a single byte frame and resync cases.
		send_frame(8'hFF, 8'h00, 32'd0);
		send_frame(8'h00, 8'hFF, 32'd1);
		// Magic pair sits at header position 1, so seven bytes are kept.
		rx_bytes = {rx_bytes, 8'hA5, 8'hA5, 8'h5A, 8'h11, 8'h22, 8'h02, 8'h00, 8'h00, 8'h00};
		rx_bytes.push_back(8'h3C);
		rx_bytes.push_back(8'hC3);
		// A lone first magic byte in the last header position is dropped.
		rx_bytes = {rx_bytes, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA5};
		send_frame(8'h01, 8'h02, 32'd2);
		random_traffic(200);
		wait_quiet();

		// Only zero-length frames pass.
		set_framing(8'h00, 8'hFF, 12'd0);
		send_frame(8'h10, 8'h20, 32'd1);
		send_frame(8'h10, 8'h21, 32'd0);
		random_traffic(100);
		wait_quiet();

		// Largest register value: the buffer size is what limits the length.
		set_framing(8'hFF, 8'h00, 12'd4095);
		send_header(8'h81, 8'h7E, 32'd4089, 8);
		send_header(8'h82, 8'h7D, 32'd4095, 8);
		send_frame(8'h83, 8'h7C, 32'd5);
		random_traffic(100);
		wait_quiet();

		// A write past the last register changes nothing.
		apb_write(4'd12, 32'hFFFF_FFFF);
		apb_read_check(REG_MAGIC_FIRST);
		apb_read_check(REG_MAGIC_SECOND);
		apb_read_check(REG_MAX_PAYLOAD);
		set_framing(8'h3C, 8'h3C, 12'd17);
		random_traffic(100);
		wait_quiet();

		repeat (3) begin
			set_framing(8'($urandom), 8'($urandom), 12'($urandom_range(0, 40)));
			random_traffic(60);
			wait_quiet();
		end

		// Back to the reset framing.
		set_framing(8'hA5, 8'h5A, 12'd4088);
		random_traffic(100);
		wait_quiet();

		repeat (10) @(posedge clk);
		if (errors == 0 && frame_words.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
